FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tegk_pkg.sv
// ----------------------------------------------------------------------------
// tegk_pkg
// Shared types, constants and tables of the tilt estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tegk_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 28;
    localparam int CORDIC_STEPS_DEF    = 24;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;
    localparam int SW       = 17;
    localparam int RATE_W   = 2 * SW;
    localparam int SUMSQ_W  = 34;
    localparam int SQ_NW    = 50;
    localparam int SQ_RW    = 26;
    localparam int CW       = 54;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN     = 4'd3;

    localparam logic [CFG_W-1:0] GYRO_SCALE_RST    = 16'd40994;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd262;
    localparam logic [CFG_W-1:0] ANGLE_GAIN_RST    = 16'd1691;
    localparam logic [CFG_W-1:0] BIAS_GAIN_RST     = 16'd1448;

    localparam logic [SQ_NW-1:0] SQ_TOP_BIT = SQ_NW'(1) << 48;
    localparam logic [35:0]      PI_Q32     = 36'd13493037705;

    localparam logic signed [OUT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_AYSQ = 3'd0;
    localparam mul_op_t MUL_AZSQ = 3'd1;
    localparam mul_op_t MUL_RATE = 3'd2;
    localparam mul_op_t MUL_DT   = 3'd3;
    localparam mul_op_t MUL_AG   = 3'd4;
    localparam mul_op_t MUL_BG   = 3'd5;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    axis;
        logic    sumsq_init;
        logic    sumsq_acc;
        logic    sq_start;
        logic    cor_start;
        logic    cor_pitch;
        logic    meas_roll_ld;
        logic    meas_pitch_ld;
        logic    err_ld;
        logic    rdiff_ld;
        logic    dt_ld;
        logic    corr_ld;
        logic    bcorr_ld;
        logic    upd;
        logic    out_ld;
    } cmd_t;

    typedef struct packed {
        logic sq_busy;
        logic cor_busy;
    } stat_t;

    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/tegk_isqrt.sv
// ----------------------------------------------------------------------------
// tegk_isqrt
// Integer square root, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module tegk_isqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [tegk_pkg::SQ_NW-1:0]    n_in,
    output logic                               busy,
    output logic [tegk_pkg::SQ_RW-1:0]         root
);

    logic [tegk_pkg::SQ_NW-1:0] n_reg;
    logic [tegk_pkg::SQ_NW-1:0] res_reg;
    logic [tegk_pkg::SQ_NW-1:0] bit_reg;
    logic                       busy_reg;
    logic [tegk_pkg::SQ_NW-1:0] trial;
    logic                       fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (n_reg >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && bit_reg[0]) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= n_in;
            res_reg <= '0;
            bit_reg <= tegk_pkg::SQ_TOP_BIT;
        end else if (busy_reg) begin
            if (fits) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[tegk_pkg::SQ_RW-1:0];

endmodule

`default_nettype wire

FILE: design/tegk_cordic.sv
// ----------------------------------------------------------------------------
// tegk_cordic
// Vectoring CORDIC for atan2, one rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tegk_cordic #(
    parameter int ANGLE_FRAC_BITS = tegk_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = tegk_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic signed [tegk_pkg::CW-1:0]     x_in,
    input  wire logic signed [tegk_pkg::CW-1:0]     y_in,
    output logic                                    busy,
    output logic signed [ANGLE_FRAC_BITS+3:0]       angle
);

    localparam int ZW  = ANGLE_FRAC_BITS + 4;
    localparam int IW  = $clog2(CORDIC_STEPS);
    localparam int RSH = 32 - ANGLE_FRAC_BITS;
    localparam logic [32:0] ATAN_HALF = 33'(1) << (RSH - 1);
    localparam logic [35:0] PI_SUM    = tegk_pkg::PI_Q32 + (36'(1) << (RSH - 1));
    localparam logic signed [ZW-1:0] PI_R = ZW'(PI_SUM >> RSH);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

    logic signed [tegk_pkg::CW-1:0] x_reg;
    logic signed [tegk_pkg::CW-1:0] y_reg;
    logic signed [ZW-1:0]           z_reg;
    logic [IW-1:0]                  cnt_reg;
    logic                           busy_reg;
    logic [31:0]                    tab;
    logic [32:0]                    atan_sum;
    logic signed [ZW-1:0]           atan_r;
    logic signed [tegk_pkg::CW-1:0] xs;
    logic signed [tegk_pkg::CW-1:0] ys;
    logic                           in_zero;

    assign tab      = tegk_pkg::atan_q32(5'(cnt_reg));
    assign atan_sum = {1'b0, tab} + ATAN_HALF;
    assign atan_r   = ZW'(atan_sum >> RSH);
    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign in_zero  = (x_in == '0) && (y_in == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= !in_zero;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (in_zero) begin
                z_reg <= '0;
            end else if (x_in < 0) begin
                z_reg <= (y_in >= 0) ? PI_R : -PI_R;
                x_reg <= -x_in;
                y_reg <= -y_in;
            end else begin
                z_reg <= '0;
                x_reg <= x_in;
                y_reg <= y_in;
            end
        end else if (busy_reg) begin
            if (!y_reg[tegk_pkg::CW-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_r;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_r;
            end
        end
    end

    assign busy  = busy_reg;
    assign angle = z_reg;

endmodule

`default_nettype wire

FILE: design/tegk_dp.sv
// ----------------------------------------------------------------------------
// tegk_dp
// Datapath: configuration, sample registers, shared multiplier, square root
// and CORDIC units, filter state and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tegk_dp #(
    parameter int ANGLE_FRAC_BITS = tegk_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = tegk_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS     = tegk_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire tegk_pkg::cmd_t                         cmd,
    output tegk_pkg::stat_t                             stat,
    input  wire logic                                   cfg_wen,
    input  wire logic [tegk_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  wire logic [tegk_pkg::CFG_W-1:0]             cfg_wdata,
    input  wire logic signed [tegk_pkg::IN_W-1:0]       s_gyro_x,
    input  wire logic signed [tegk_pkg::IN_W-1:0]       s_gyro_y,
    input  wire logic signed [tegk_pkg::IN_W-1:0]       s_accel_x,
    input  wire logic signed [tegk_pkg::IN_W-1:0]       s_accel_y,
    input  wire logic signed [tegk_pkg::IN_W-1:0]       s_accel_z,
    output logic signed [tegk_pkg::OUT_W-1:0]           m_roll_angle,
    output logic signed [tegk_pkg::OUT_W-1:0]           m_pitch_angle,
    output logic signed [tegk_pkg::OUT_W-1:0]           m_roll_rate_bias,
    output logic signed [tegk_pkg::OUT_W-1:0]           m_pitch_rate_bias
);

    localparam int SW   = tegk_pkg::SW;
    localparam int CW   = tegk_pkg::CW;
    localparam int ZW   = ANGLE_FRAC_BITS + 4;
    localparam int EW   = ((ZW > 32) ? ZW : 32) + 1;
    localparam int AW   = (EW > 35) ? EW : 35;
    localparam int BW   = SW;
    localparam int PW   = AW + BW;
    localparam int PW1  = PW + 1;
    localparam int RW   = PW1 - 16;
    localparam int SUMW = RW + 2;
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(tegk_pkg::Q_MAX);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(tegk_pkg::Q_MIN);

    function automatic logic signed [SW-1:0] sext(input logic [tegk_pkg::IN_W-1:0] raw);
        logic [SW-1:0] v;
        logic          sgn;
        sgn = raw[(SAMPLE_BITS <= tegk_pkg::IN_W) ? SAMPLE_BITS - 1 : tegk_pkg::IN_W - 1];
        v = {1'b0, raw};
        for (int k = 0; k < SW; k++) begin
            if (k >= SAMPLE_BITS) begin
                v[k] = sgn;
            end
        end
        return $signed(v);
    endfunction

    function automatic logic signed [tegk_pkg::OUT_W-1:0] sat32(
        input logic signed [SUMW-1:0] v
    );
        logic signed [tegk_pkg::OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = tegk_pkg::Q_MAX;
        end else if (v < SAT_LO) begin
            r = tegk_pkg::Q_MIN;
        end else begin
            r = $signed(v[tegk_pkg::OUT_W-1:0]);
        end
        return r;
    endfunction

    logic [tegk_pkg::CFG_W-1:0] gyro_scale_reg;
    logic [tegk_pkg::CFG_W-1:0] sample_period_reg;
    logic [tegk_pkg::CFG_W-1:0] angle_gain_reg;
    logic [tegk_pkg::CFG_W-1:0] bias_gain_reg;

    logic signed [SW-1:0] gx_reg, gy_reg, ax_reg, ay_reg, az_reg;

    logic signed [AW-1:0]  a_op;
    logic signed [BW-1:0]  b_op;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW1-1:0] rnd_sum;
    logic signed [RW-1:0]  rnd_val;

    logic [tegk_pkg::SUMSQ_W-1:0] sumsq_reg;
    logic [tegk_pkg::SQ_RW-1:0]   root;
    logic                         sq_busy;

    logic signed [CW-1:0] cor_x, cor_y;
    logic signed [ZW-1:0] angle;
    logic                 cor_busy;

    logic signed [ZW-1:0] roll_meas_reg, pitch_meas_reg;
    logic signed [tegk_pkg::OUT_W-1:0] roll_est_reg, pitch_est_reg;
    logic signed [tegk_pkg::OUT_W-1:0] roll_bias_reg, pitch_bias_reg;

    logic signed [ZW-1:0]              meas_sel;
    logic signed [tegk_pkg::OUT_W-1:0] est_sel, bias_sel;
    logic signed [SW-1:0]              count_sel;
    logic signed [tegk_pkg::RATE_W-1:0] rate;

    logic signed [AW-1:0] err_reg, rdiff_reg;
    logic signed [RW-1:0] dt_reg, corr_reg, bcorr_reg;
    logic signed [tegk_pkg::OUT_W-1:0] est_new, bias_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_scale_reg    <= tegk_pkg::GYRO_SCALE_RST;
            sample_period_reg <= tegk_pkg::SAMPLE_PERIOD_RST;
            angle_gain_reg    <= tegk_pkg::ANGLE_GAIN_RST;
            bias_gain_reg     <= tegk_pkg::BIAS_GAIN_RST;
        end else if (cfg_wen) begin
            case (cfg_idx)
                tegk_pkg::REG_GYRO_SCALE:    gyro_scale_reg    <= cfg_wdata;
                tegk_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata;
                tegk_pkg::REG_ANGLE_GAIN:    angle_gain_reg    <= cfg_wdata;
                tegk_pkg::REG_BIAS_GAIN:     bias_gain_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gx_reg <= sext(s_gyro_x);
            gy_reg <= sext(s_gyro_y);
            ax_reg <= sext(s_accel_x);
            ay_reg <= sext(s_accel_y);
            az_reg <= sext(s_accel_z);
        end
    end

    assign meas_sel  = cmd.axis ? pitch_meas_reg : roll_meas_reg;
    assign est_sel   = cmd.axis ? pitch_est_reg  : roll_est_reg;
    assign bias_sel  = cmd.axis ? pitch_bias_reg : roll_bias_reg;
    assign count_sel = cmd.axis ? gy_reg : gx_reg;
    assign rate      = $signed(prod_reg[tegk_pkg::RATE_W-1:0]);

    always_comb begin
        case (cmd.mul_op)
            tegk_pkg::MUL_AYSQ: begin
                a_op = AW'(ay_reg);
                b_op = ay_reg;
            end
            tegk_pkg::MUL_AZSQ: begin
                a_op = AW'(az_reg);
                b_op = az_reg;
            end
            tegk_pkg::MUL_RATE: begin
                a_op = AW'(count_sel);
                b_op = $signed({1'b0, gyro_scale_reg});
            end
            tegk_pkg::MUL_DT: begin
                a_op = rdiff_reg;
                b_op = $signed({1'b0, sample_period_reg});
            end
            tegk_pkg::MUL_AG: begin
                a_op = err_reg;
                b_op = $signed({1'b0, angle_gain_reg});
            end
            tegk_pkg::MUL_BG: begin
                a_op = err_reg;
                b_op = $signed({1'b0, bias_gain_reg});
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_op * b_op;
    end

    assign rnd_sum = PW1'(prod_reg) + PW1'(32768);
    assign rnd_val = RW'(rnd_sum >>> 16);

    always_ff @(posedge aclk) begin
        if (cmd.sumsq_init) begin
            sumsq_reg <= prod_reg[tegk_pkg::SUMSQ_W-1:0];
        end else if (cmd.sumsq_acc) begin
            sumsq_reg <= sumsq_reg + prod_reg[tegk_pkg::SUMSQ_W-1:0];
        end
    end

    tegk_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sq_start),
        .n_in    ({sumsq_reg, 16'b0}),
        .busy    (sq_busy),
        .root    (root)
    );

    always_comb begin
        if (cmd.cor_pitch) begin
            cor_x = CW'($signed({1'b0, root})) <<< 24;
            cor_y = -(CW'(ax_reg) <<< 32);
        end else begin
            cor_x = CW'(az_reg) <<< 32;
            cor_y = CW'(ay_reg) <<< 32;
        end
    end

    tegk_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cor_start),
        .x_in    (cor_x),
        .y_in    (cor_y),
        .busy    (cor_busy),
        .angle   (angle)
    );

    always_ff @(posedge aclk) begin
        if (cmd.meas_roll_ld) begin
            roll_meas_reg <= angle;
        end
        if (cmd.meas_pitch_ld) begin
            pitch_meas_reg <= angle;
        end
        if (cmd.err_ld) begin
            err_reg <= AW'(meas_sel) - AW'(est_sel);
        end
        if (cmd.rdiff_ld) begin
            rdiff_reg <= AW'(rate) - AW'(bias_sel);
        end
        if (cmd.dt_ld) begin
            dt_reg <= rnd_val;
        end
        if (cmd.corr_ld) begin
            corr_reg <= rnd_val;
        end
        if (cmd.bcorr_ld) begin
            bcorr_reg <= rnd_val;
        end
    end

    assign est_new  = sat32(SUMW'(est_sel) + SUMW'(dt_reg) + SUMW'(corr_reg));
    assign bias_new = sat32(SUMW'(bias_sel) - SUMW'(bcorr_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_est_reg   <= '0;
            pitch_est_reg  <= '0;
            roll_bias_reg  <= '0;
            pitch_bias_reg <= '0;
        end else if (cmd.upd) begin
            if (cmd.axis) begin
                pitch_est_reg  <= est_new;
                pitch_bias_reg <= bias_new;
            end else begin
                roll_est_reg  <= est_new;
                roll_bias_reg <= bias_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_roll_angle      <= roll_est_reg;
            m_pitch_angle     <= pitch_est_reg;
            m_roll_rate_bias  <= roll_bias_reg;
            m_pitch_rate_bias <= pitch_bias_reg;
        end
    end

    assign stat.sq_busy  = sq_busy;
    assign stat.cor_busy = cor_busy;

endmodule

`default_nettype wire

FILE: design/tegk_ctrl.sv
// ----------------------------------------------------------------------------
// tegk_ctrl
// Sequencer that steps the datapath through one sample and runs both
// handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tegk_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire tegk_pkg::stat_t stat,
    output tegk_pkg::cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ1   = 4'd1;
    localparam logic [3:0] ST_SQ2   = 4'd2;
    localparam logic [3:0] ST_SQ3   = 4'd3;
    localparam logic [3:0] ST_SQ4   = 4'd4;
    localparam logic [3:0] ST_WAIT1 = 4'd5;
    localparam logic [3:0] ST_A0    = 4'd6;
    localparam logic [3:0] ST_A1    = 4'd7;
    localparam logic [3:0] ST_A2    = 4'd8;
    localparam logic [3:0] ST_A3    = 4'd9;
    localparam logic [3:0] ST_A4    = 4'd10;
    localparam logic [3:0] ST_A5    = 4'd11;
    localparam logic [3:0] ST_A6    = 4'd12;
    localparam logic [3:0] ST_WAIT2 = 4'd13;
    localparam logic [3:0] ST_DONE  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       axis_reg, axis_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1: begin
                cmd.mul_op = tegk_pkg::MUL_AYSQ;
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                cmd.mul_op     = tegk_pkg::MUL_AZSQ;
                cmd.sumsq_init = 1'b1;
                cmd.cor_start  = 1'b1;
                state_next     = ST_SQ3;
            end
            ST_SQ3: begin
                cmd.sumsq_acc = 1'b1;
                state_next    = ST_SQ4;
            end
            ST_SQ4: begin
                cmd.sq_start = 1'b1;
                state_next   = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (!stat.sq_busy && !stat.cor_busy) begin
                    cmd.meas_roll_ld = 1'b1;
                    cmd.cor_start    = 1'b1;
                    cmd.cor_pitch    = 1'b1;
                    axis_next        = 1'b0;
                    state_next       = ST_A0;
                end
            end
            ST_A0: begin
                cmd.mul_op = tegk_pkg::MUL_RATE;
                cmd.err_ld = 1'b1;
                state_next = ST_A1;
            end
            ST_A1: begin
                cmd.rdiff_ld = 1'b1;
                state_next   = ST_A2;
            end
            ST_A2: begin
                cmd.mul_op = tegk_pkg::MUL_DT;
                state_next = ST_A3;
            end
            ST_A3: begin
                cmd.dt_ld  = 1'b1;
                cmd.mul_op = tegk_pkg::MUL_AG;
                state_next = ST_A4;
            end
            ST_A4: begin
                cmd.corr_ld = 1'b1;
                cmd.mul_op  = tegk_pkg::MUL_BG;
                state_next  = ST_A5;
            end
            ST_A5: begin
                cmd.bcorr_ld = 1'b1;
                state_next   = ST_A6;
            end
            ST_A6: begin
                cmd.upd    = 1'b1;
                state_next = axis_reg ? ST_DONE : ST_WAIT2;
            end
            ST_WAIT2: begin
                if (!stat.cor_busy) begin
                    cmd.meas_pitch_ld = 1'b1;
                    axis_next         = 1'b1;
                    state_next        = ST_A0;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: design/tilt_estimator_gyro_bias_kalman.sv
// ----------------------------------------------------------------------------
// tilt_estimator_gyro_bias_kalman
// Fixed-gain Kalman tilt estimator for roll and pitch with gyro bias tracking.
// ----------------------------------------------------------------------------
// The block takes one sample at a time and returns one result per sample.
// The square root runs beside the roll rotation and, with the default
// settings, outlasts it, so it sets when the pitch rotation can start on the
// single CORDIC unit, one rotation per cycle. The roll filter update overlaps
// the pitch rotation; the pitch update, the result load and the return to
// ready follow it, and the result load waits while an earlier result is unread.
// A finished result waits in its own register, so the next sample is taken
// while the previous result has not yet been read.
`default_nettype none

module tilt_estimator_gyro_bias_kalman #(
    parameter int ANGLE_FRAC_BITS = tegk_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = tegk_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS     = tegk_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wen,
    input  wire logic [tegk_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [tegk_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [tegk_pkg::IN_W-1:0]    s_gyro_x,
    input  wire logic signed [tegk_pkg::IN_W-1:0]    s_gyro_y,
    input  wire logic signed [tegk_pkg::IN_W-1:0]    s_accel_x,
    input  wire logic signed [tegk_pkg::IN_W-1:0]    s_accel_y,
    input  wire logic signed [tegk_pkg::IN_W-1:0]    s_accel_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [tegk_pkg::OUT_W-1:0]        m_roll_angle,
    output logic signed [tegk_pkg::OUT_W-1:0]        m_pitch_angle,
    output logic signed [tegk_pkg::OUT_W-1:0]        m_roll_rate_bias,
    output logic signed [tegk_pkg::OUT_W-1:0]        m_pitch_rate_bias
);

    tegk_pkg::cmd_t  cmd;
    tegk_pkg::stat_t stat;

    tegk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tegk_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wen           (cfg_wen),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .s_gyro_x          (s_gyro_x),
        .s_gyro_y          (s_gyro_y),
        .s_accel_x         (s_accel_x),
        .s_accel_y         (s_accel_y),
        .s_accel_z         (s_accel_z),
        .m_roll_angle      (m_roll_angle),
        .m_pitch_angle     (m_pitch_angle),
        .m_roll_rate_bias  (m_roll_rate_bias),
        .m_pitch_rate_bias (m_pitch_rate_bias)
    );

endmodule

`default_nettype wire

FILE: design/tegk_checker.sv
// ----------------------------------------------------------------------------
// tegk_checker
// Port-level checks of the tilt estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tegk_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic signed [tegk_pkg::OUT_W-1:0] m_roll_angle,
    input wire logic signed [tegk_pkg::OUT_W-1:0] m_pitch_angle,
    input wire logic signed [tegk_pkg::OUT_W-1:0] m_roll_rate_bias,
    input wire logic signed [tegk_pkg::OUT_W-1:0] m_pitch_rate_bias
);

    // A waiting result stays put until it is taken.
    `ASSERT_CLK(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_roll_angle) && $stable(m_pitch_angle) && $stable(m_roll_rate_bias) && $stable(m_pitch_rate_bias), "result changed while stalled")

    // Only one request is in work at a time.
    `ASSERT_CLK(a_one_in_work, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request taken while busy")

    // A new result is shown only as the sequencer leaves its final step.
    `ASSERT_CLK(a_result_after_work, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result without finished work")

    `ASSERT_CLK_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind tilt_estimator_gyro_bias_kalman tegk_checker u_tegk_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_roll_angle      (m_roll_angle),
    .m_pitch_angle     (m_pitch_angle),
    .m_roll_rate_bias  (m_roll_rate_bias),
    .m_pitch_rate_bias (m_pitch_rate_bias)
);

`default_nettype wire
